@@ hw/rtl/soil_retention_curve_eval_assert.svh @@
// ----------------------------------------------------------------------------
// Soil retention curve evaluator assertion macros
// Concurrent assertion wrappers, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SOIL_RETENTION_CURVE_EVAL_ASSERT_SVH
`define SOIL_RETENTION_CURVE_EVAL_ASSERT_SVH
`ifndef SYNTHESIS
`define SRCE_ASSERT(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("srce assertion failed");
`define SRCE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("srce assertion failed");
`else
`define SRCE_ASSERT(lbl, expr)
`define SRCE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/srce_pkg.sv @@
// ----------------------------------------------------------------------------
// Soil retention curve evaluator package
// Widths, the sideband record that travels with each transaction, and the
// constant root table of the fixed-point exponential.
// ----------------------------------------------------------------------------
package srce_pkg;

   localparam int LOG_LANES      = 3;
   localparam int LOG_ARG_BITS   = 40;
   localparam int LOG_WORD_BITS  = 64;
   localparam int LOG_NORM_STEPS = 6;
   localparam int LOG_INT_BITS   = 6;
   localparam int LOG_FRAC       = 20;
   localparam int LOG_BITS       = LOG_INT_BITS + LOG_FRAC;

   localparam int EXP_LANES = 2;

   localparam int DIV_LANES    = 2;
   localparam int DIV_BITS     = 64;
   localparam int DIV_DEN_BITS = 33;

   localparam logic [31:0] EXP_ONE = 32'h8000_0000;
   localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
   localparam logic [16:0] ONE_Q16 = 17'h1_0000;
   localparam logic [31:0] CAP_MAX = 32'hFFFF_FFFF;

   localparam logic [2:0] CSR_SAT_MOISTURE      = 3'd0;
   localparam logic [2:0] CSR_RESIDUAL_MOISTURE = 3'd1;
   localparam logic [2:0] CSR_RETENTION_ALPHA   = 3'd2;
   localparam logic [2:0] CSR_RETENTION_BETA    = 3'd3;
   localparam logic [2:0] CSR_PERM_GAMMA        = 3'd4;
   localparam logic [2:0] CSR_PERM_COEFF        = 3'd5;
   localparam logic [2:0] CSR_SPECIFIC_STORAGE  = 3'd6;

   typedef struct packed {
      logic             valid;
      logic             neg;
      logic [31:0]      x;
      logic [1:0]       dneg;
      logic [1:0]       big;
      logic [1:0][5:0]  shift;
      logic [15:0]      theta;
      logic [16:0]      kr;
   } carry_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= v) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // Successive square roots of two in Q1.31, each taken from the last.
   function automatic logic [LOG_FRAC-1:0][31:0] exp2_roots();
      logic [63:0] c;
      logic [LOG_FRAC-1:0][31:0] t;
      c = 64'd1 << 32;
      for (int j = 0; j < LOG_FRAC; j++) begin
         c = isqrt64(c << 31);
         t[j] = c[31:0];
      end
      return t;
   endfunction

   localparam logic [LOG_FRAC-1:0][31:0] EXP2_ROOT = exp2_roots();

endpackage

@@ hw/rtl/srce_log2.sv @@
// ----------------------------------------------------------------------------
// Pipelined base-2 logarithm
// Three lanes; leading-one normalization in six steps, then one fraction bit
// per stage by squaring the Q1.31 mantissa.
// ----------------------------------------------------------------------------
module srce_log2 import srce_pkg::*; (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [LOG_LANES-1:0][LOG_ARG_BITS-1:0]   log_arg,
   input  carry_type                                carry_in,
   output logic [LOG_LANES-1:0][LOG_BITS-1:0]       log_val,
   output carry_type                                carry_out
);

   logic [LOG_LANES-1:0][LOG_WORD_BITS-1:0] norm_w_ff [0:LOG_NORM_STEPS];
   logic [LOG_LANES-1:0][LOG_INT_BITS-1:0]  norm_z_ff [0:LOG_NORM_STEPS];
   carry_type                               norm_c_ff [0:LOG_NORM_STEPS];

   logic [LOG_LANES-1:0][31:0]              sq_m_ff [0:LOG_FRAC];
   logic [LOG_LANES-1:0][LOG_INT_BITS-1:0]  sq_e_ff [0:LOG_FRAC];
   logic [LOG_LANES-1:0][LOG_FRAC-1:0]      sq_f_ff [0:LOG_FRAC];
   carry_type                               sq_c_ff [0:LOG_FRAC];

   always_ff @(posedge clock) begin
      for (int l = 0; l < LOG_LANES; l++) begin
         norm_w_ff[0][l] <= LOG_WORD_BITS'(log_arg[l]);
      end
      norm_z_ff[0] <= '0;
      norm_c_ff[0] <= carry_in;
      if (reset) begin
         norm_c_ff[0].valid <= 1'b0;
      end
   end

   for (genvar s = 0; s < LOG_NORM_STEPS; s++) begin : g_norm
      localparam int SH = (LOG_WORD_BITS / 2) >> s;
      logic [LOG_LANES-1:0][LOG_WORD_BITS-1:0] w_in;
      logic [LOG_LANES-1:0][LOG_INT_BITS-1:0]  z_in;

      always_comb begin
         for (int l = 0; l < LOG_LANES; l++) begin
            if (norm_w_ff[s][l][LOG_WORD_BITS-1 -: SH] == '0) begin
               w_in[l] = norm_w_ff[s][l] << SH;
               z_in[l] = norm_z_ff[s][l] | LOG_INT_BITS'(SH);
            end else begin
               w_in[l] = norm_w_ff[s][l];
               z_in[l] = norm_z_ff[s][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         norm_w_ff[s+1] <= w_in;
         norm_z_ff[s+1] <= z_in;
         norm_c_ff[s+1] <= norm_c_ff[s];
         if (reset) begin
            norm_c_ff[s+1].valid <= 1'b0;
         end
      end
   end

   // The top word of the normalized value is the mantissa, truncated when
   // the argument is wider than 32 bits.
   always_ff @(posedge clock) begin
      for (int l = 0; l < LOG_LANES; l++) begin
         sq_m_ff[0][l] <= norm_w_ff[LOG_NORM_STEPS][l][LOG_WORD_BITS-1 -: 32];
         sq_e_ff[0][l] <= LOG_INT_BITS'(LOG_WORD_BITS - 1) - norm_z_ff[LOG_NORM_STEPS][l];
      end
      sq_f_ff[0] <= '0;
      sq_c_ff[0] <= norm_c_ff[LOG_NORM_STEPS];
      if (reset) begin
         sq_c_ff[0].valid <= 1'b0;
      end
   end

   for (genvar j = 0; j < LOG_FRAC; j++) begin : g_square
      logic [LOG_LANES-1:0][31:0]         m_in;
      logic [LOG_LANES-1:0][LOG_FRAC-1:0] f_in;

      always_comb begin
         logic [63:0] prod;
         logic [32:0] t;
         for (int l = 0; l < LOG_LANES; l++) begin
            prod = 64'(sq_m_ff[j][l]) * 64'(sq_m_ff[j][l]);
            t    = prod[63:31];
            if (t[32]) begin
               m_in[l] = t[32:1];
               f_in[l] = {sq_f_ff[j][l][LOG_FRAC-2:0], 1'b1};
            end else begin
               m_in[l] = t[31:0];
               f_in[l] = {sq_f_ff[j][l][LOG_FRAC-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         sq_m_ff[j+1] <= m_in;
         sq_f_ff[j+1] <= f_in;
         sq_e_ff[j+1] <= sq_e_ff[j];
         sq_c_ff[j+1] <= sq_c_ff[j];
         if (reset) begin
            sq_c_ff[j+1].valid <= 1'b0;
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LOG_LANES; l++) begin
         log_val[l] = {sq_e_ff[LOG_FRAC][l], sq_f_ff[LOG_FRAC][l]};
      end
   end

   assign carry_out = sq_c_ff[LOG_FRAC];

endmodule

@@ hw/rtl/srce_exp2.sv @@
// ----------------------------------------------------------------------------
// Pipelined fractional power of two
// Two lanes; each stage multiplies in one constant root when its fraction bit
// is set, product truncated to Q1.31.
// ----------------------------------------------------------------------------
module srce_exp2 import srce_pkg::*; (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [EXP_LANES-1:0][LOG_FRAC-1:0]   exp_frac,
   input  carry_type                            carry_in,
   output logic [EXP_LANES-1:0][31:0]           exp_val,
   output carry_type                            carry_out
);

   logic [EXP_LANES-1:0][31:0]       m_ff [0:LOG_FRAC];
   logic [EXP_LANES-1:0][LOG_FRAC-1:0] f_ff [0:LOG_FRAC];
   carry_type                        c_ff [0:LOG_FRAC];

   always_ff @(posedge clock) begin
      for (int l = 0; l < EXP_LANES; l++) begin
         m_ff[0][l] <= EXP_ONE;
      end
      f_ff[0] <= exp_frac;
      c_ff[0] <= carry_in;
      if (reset) begin
         c_ff[0].valid <= 1'b0;
      end
   end

   for (genvar j = 0; j < LOG_FRAC; j++) begin : g_step
      logic [EXP_LANES-1:0][31:0] m_in;

      always_comb begin
         logic [63:0] prod;
         for (int l = 0; l < EXP_LANES; l++) begin
            prod = 64'(m_ff[j][l]) * 64'(EXP2_ROOT[j]);
            if (f_ff[j][l][LOG_FRAC-1-j]) begin
               m_in[l] = prod[62:31];
            end else begin
               m_in[l] = m_ff[j][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         m_ff[j+1] <= m_in;
         f_ff[j+1] <= f_ff[j];
         c_ff[j+1] <= c_ff[j];
         if (reset) begin
            c_ff[j+1].valid <= 1'b0;
         end
      end
   end

   assign exp_val   = m_ff[LOG_FRAC];
   assign carry_out = c_ff[LOG_FRAC];

endmodule

@@ hw/rtl/srce_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Two lanes of 64-bit by 33-bit unsigned division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module srce_div import srce_pkg::*; (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [DIV_LANES-1:0][DIV_BITS-1:0]       div_num,
   input  logic [DIV_LANES-1:0][DIV_DEN_BITS-1:0]   div_den,
   input  carry_type                                carry_in,
   output logic [DIV_LANES-1:0][DIV_BITS-1:0]       div_quo,
   output carry_type                                carry_out
);

   `include "soil_retention_curve_eval_assert.svh"

   logic [DIV_LANES-1:0][DIV_BITS-1:0]     n_ff   [0:DIV_BITS];
   logic [DIV_LANES-1:0][DIV_DEN_BITS-1:0] rem_ff [0:DIV_BITS];
   logic [DIV_LANES-1:0][DIV_DEN_BITS-1:0] d_ff   [0:DIV_BITS];
   carry_type                              c_ff   [0:DIV_BITS];

   always_ff @(posedge clock) begin
      n_ff[0]   <= div_num;
      rem_ff[0] <= '0;
      d_ff[0]   <= div_den;
      c_ff[0]   <= carry_in;
      if (reset) begin
         c_ff[0].valid <= 1'b0;
      end
   end

   for (genvar s = 0; s < DIV_BITS; s++) begin : g_step
      logic [DIV_LANES-1:0][DIV_BITS-1:0]     n_in;
      logic [DIV_LANES-1:0][DIV_DEN_BITS-1:0] rem_in;

      always_comb begin
         logic [DIV_DEN_BITS:0] t;
         for (int l = 0; l < DIV_LANES; l++) begin
            t = {rem_ff[s][l], n_ff[s][l][DIV_BITS-1]};
            if (t >= {1'b0, d_ff[s][l]}) begin
               rem_in[l] = DIV_DEN_BITS'(t - {1'b0, d_ff[s][l]});
               n_in[l]   = {n_ff[s][l][DIV_BITS-2:0], 1'b1};
            end else begin
               rem_in[l] = t[DIV_DEN_BITS-1:0];
               n_in[l]   = {n_ff[s][l][DIV_BITS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         n_ff[s+1]   <= n_in;
         rem_ff[s+1] <= rem_in;
         d_ff[s+1]   <= d_ff[s];
         c_ff[s+1]   <= c_ff[s];
         if (reset) begin
            c_ff[s+1].valid <= 1'b0;
         end
      end
   end

   assign div_quo   = n_ff[DIV_BITS];
   assign carry_out = c_ff[DIV_BITS];

   // A finished division always leaves a remainder below a nonzero divisor.
   for (genvar l = 0; l < DIV_LANES; l++) begin : g_check
      `SRCE_ASSERT(a_rem_below_den, !c_ff[DIV_BITS].valid || (d_ff[DIV_BITS][l] == '0) || (rem_ff[DIV_BITS][l] < d_ff[DIV_BITS][l]))
   end

endmodule

@@ hw/rtl/soil_retention_curve_eval.sv @@
// ----------------------------------------------------------------------------
// Soil retention curve evaluator
// Per-cell retention and permeability curve evaluation in fixed point.
// ----------------------------------------------------------------------------
// The block accepts one pressure head per clock cycle whenever busy is low;
// busy is high only right after reset. Each transaction returns moisture,
// saturation ratio, relative permeability and moisture capacity after it is
// accepted, in order, marked by rsp_valid for one cycle. The receiver cannot
// stall, so results must be captured when shown. The pipeline holds 28
// stages of logarithm, 21 of exponential, and two 65-stage restoring
// dividers (one for the curve reciprocal, one for the capacity and
// saturation quotients), plus surrounding arithmetic stages. The user must
// write registers through the csr port only while no transaction is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module soil_retention_curve_eval import srce_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_head,
   output logic               rsp_valid,
   output logic [15:0]        rsp_moisture,
   output logic [16:0]        rsp_saturation_ratio,
   output logic [16:0]        rsp_rel_permeability,
   output logic [31:0]        rsp_moisture_capacity,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [39:0]        csr_wdata
);

   `include "soil_retention_curve_eval_assert.svh"

   // Configuration registers.
   logic [15:0] sat_moisture_ff;
   logic [15:0] residual_moisture_ff;
   logic [39:0] retention_alpha_ff;
   logic [15:0] retention_beta_ff;
   logic [15:0] perm_gamma_ff;
   logic [39:0] perm_coeff_ff;
   logic [31:0] specific_storage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_moisture_ff      <= 16'd18809;
         residual_moisture_ff <= 16'd4915;
         retention_alpha_ff   <= 40'd412416000;
         retention_beta_ff    <= 16'd16220;
         perm_gamma_ff        <= 16'd19415;
         perm_coeff_ff        <= 40'd300800000;
         specific_storage_ff  <= 32'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SAT_MOISTURE:      sat_moisture_ff      <= csr_wdata[15:0];
            CSR_RESIDUAL_MOISTURE: residual_moisture_ff <= csr_wdata[15:0];
            CSR_RETENTION_ALPHA:   retention_alpha_ff   <= csr_wdata;
            CSR_RETENTION_BETA:    retention_beta_ff    <= csr_wdata[15:0];
            CSR_PERM_GAMMA:        perm_gamma_ff        <= csr_wdata[15:0];
            CSR_PERM_COEFF:        perm_coeff_ff        <= csr_wdata;
            CSR_SPECIFIC_STORAGE:  specific_storage_ff  <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   logic [15:0] diff;
   assign diff = (residual_moisture_ff < sat_moisture_ff) ?
                 (sat_moisture_ff - residual_moisture_ff) : 16'd0;

   logic busy_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end
   assign busy = busy_ff;

   // Input stage.
   carry_type in_c_ff;
   carry_type in_c_in;

   always_comb begin
      in_c_in       = '0;
      in_c_in.valid = start && !busy_ff;
      in_c_in.neg   = req_head[31];
      in_c_in.x     = $unsigned(~req_head) + 32'd1;
   end

   always_ff @(posedge clock) begin
      in_c_ff <= in_c_in;
      if (reset) begin
         in_c_ff.valid <= 1'b0;
      end
   end

   // Logarithms of -h (|h| for a negative head) and of both curve
   // coefficients; zero coefficients count as one LSB.
   logic [LOG_LANES-1:0][LOG_ARG_BITS-1:0] log_arg;
   logic [LOG_LANES-1:0][LOG_BITS-1:0]     log_val;
   carry_type                              log_c;

   assign log_arg[0] = LOG_ARG_BITS'(in_c_ff.x);
   assign log_arg[1] = (retention_alpha_ff == '0) ? 40'd1 : retention_alpha_ff;
   assign log_arg[2] = (perm_coeff_ff == '0) ? 40'd1 : perm_coeff_ff;

   srce_log2 u_log2 (
      .clock     (clock),
      .reset     (reset),
      .log_arg   (log_arg),
      .carry_in  (in_c_ff),
      .log_val   (log_val),
      .carry_out (log_c)
   );

   // Curve exponents in Q4.12 give the exponent D in Q.32: lane 0 retention, lane 1 permeability.
   logic [EXP_LANES-1:0][15:0] expo;
   assign expo[0] = retention_beta_ff;
   assign expo[1] = perm_gamma_ff;

   logic [EXP_LANES-1:0][46:0] ex_d_ff;
   logic [EXP_LANES-1:0][46:0] ex_d_in;
   carry_type                  ex_c_ff;

   always_comb begin
      logic [41:0] prod;
      for (int l = 0; l < EXP_LANES; l++) begin
         prod = 42'(expo[l]) * 42'(log_val[0]);
         ex_d_in[l] = 47'(prod) - 47'({expo[l], 23'd0}) - 47'({log_val[l+1], 12'd0})
                      + (47'd8 << 32);
      end
   end

   always_ff @(posedge clock) begin
      ex_d_ff <= ex_d_in;
      ex_c_ff <= log_c;
      if (reset) begin
         ex_c_ff.valid <= 1'b0;
      end
   end

   // Magnitude split into integer and fraction parts.
   logic [EXP_LANES-1:0][LOG_FRAC-1:0] mg_frac_ff;
   logic [EXP_LANES-1:0][LOG_FRAC-1:0] mg_frac_in;
   carry_type                          mg_c_ff;
   carry_type                          mg_c_in;

   always_comb begin
      logic [46:0] mag;
      logic [14:0] k;
      mg_c_in = ex_c_ff;
      for (int l = 0; l < EXP_LANES; l++) begin
         mag              = ex_d_ff[l][46] ? (~ex_d_ff[l] + 47'd1) : ex_d_ff[l];
         k                = mag[46:32];
         mg_c_in.dneg[l]  = ex_d_ff[l][46];
         mg_c_in.big[l]   = (k > 15'd40);
         mg_c_in.shift[l] = k[5:0];
         mg_frac_in[l]    = mag[31:12];
      end
   end

   always_ff @(posedge clock) begin
      mg_frac_ff <= mg_frac_in;
      mg_c_ff    <= mg_c_in;
      if (reset) begin
         mg_c_ff.valid <= 1'b0;
      end
   end

   logic [EXP_LANES-1:0][31:0] exp_m;
   carry_type                  exp_c;

   srce_exp2 u_exp2 (
      .clock     (clock),
      .reset     (reset),
      .exp_frac  (mg_frac_ff),
      .carry_in  (mg_c_ff),
      .exp_val   (exp_m),
      .carry_out (exp_c)
   );

   // Reciprocal of 1 + 2^|D|, scaled so the quotient needs only a final shift.
   logic [DIV_LANES-1:0][DIV_BITS-1:0]     div1_num;
   logic [DIV_LANES-1:0][DIV_DEN_BITS-1:0] div1_den;
   logic [DIV_LANES-1:0][DIV_BITS-1:0]     div1_q;
   carry_type                              div1_c;

   always_comb begin
      for (int l = 0; l < DIV_LANES; l++) begin
         div1_num[l] = {1'b1, {(DIV_BITS-1){1'b0}}};
         div1_den[l] = ((33'd1 << 31) >> exp_c.shift[l]) + {1'b0, exp_m[l]};
      end
   end

   srce_div u_div_logistic (
      .clock     (clock),
      .reset     (reset),
      .div_num   (div1_num),
      .div_den   (div1_den),
      .carry_in  (exp_c),
      .div_quo   (div1_q),
      .carry_out (div1_c)
   );

   logic [EXP_LANES-1:0][32:0] r_ff;
   logic [EXP_LANES-1:0][32:0] r_in;
   carry_type                  r_c_ff;

   always_comb begin
      logic [32:0] s;
      for (int l = 0; l < EXP_LANES; l++) begin
         s       = div1_c.big[l] ? 33'd0 : 33'(div1_q[l] >> div1_c.shift[l]);
         r_in[l] = div1_c.dneg[l] ? (ONE_Q32 - s) : s;
      end
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      r_c_ff <= div1_c;
      if (reset) begin
         r_c_ff.valid <= 1'b0;
      end
   end

   // Moisture, permeability and the r(1-r) product.
   logic [31:0] th_rr_ff;
   logic [31:0] th_rr_in;
   carry_type   th_c_ff;
   carry_type   th_c_in;

   always_comb begin
      logic [65:0] rrp;
      logic [48:0] tp;
      rrp     = 66'(r_ff[0]) * 66'(ONE_Q32 - r_ff[0]);
      tp      = 49'(diff) * 49'(r_ff[0]);
      th_rr_in = rrp[63:32];
      th_c_in  = r_c_ff;
      if (r_c_ff.neg) begin
         th_c_in.theta = residual_moisture_ff + tp[47:32];
         th_c_in.kr    = r_ff[1][32:16];
      end else begin
         th_c_in.theta = sat_moisture_ff;
         th_c_in.kr    = ONE_Q16;
      end
   end

   always_ff @(posedge clock) begin
      th_rr_ff <= th_rr_in;
      th_c_ff  <= th_c_in;
      if (reset) begin
         th_c_ff.valid <= 1'b0;
      end
   end

   logic [47:0] p1_ff;
   logic [47:0] p1_in;
   carry_type   p1_c_ff;

   assign p1_in = 48'(th_rr_ff) * 48'(diff);

   always_ff @(posedge clock) begin
      p1_ff   <= p1_in;
      p1_c_ff <= th_c_ff;
      if (reset) begin
         p1_c_ff.valid <= 1'b0;
      end
   end

   logic [63:0] n_ff;
   logic [63:0] n_in;
   carry_type   n_c_ff;

   assign n_in = 64'(p1_ff) * 64'(retention_beta_ff);

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      n_c_ff <= p1_c_ff;
      if (reset) begin
         n_c_ff.valid <= 1'b0;
      end
   end

   // Lane 0 is the capacity quotient, lane 1 the saturation ratio.
   logic [DIV_LANES-1:0][DIV_BITS-1:0]     div2_num;
   logic [DIV_LANES-1:0][DIV_DEN_BITS-1:0] div2_den;
   logic [DIV_LANES-1:0][DIV_BITS-1:0]     div2_q;
   carry_type                              div2_c;

   assign div2_num[0] = DIV_BITS'(n_ff[63:20]);
   assign div2_den[0] = DIV_DEN_BITS'(n_c_ff.x);
   assign div2_num[1] = DIV_BITS'({n_c_ff.theta, 16'd0});
   assign div2_den[1] = DIV_DEN_BITS'(sat_moisture_ff);

   srce_div u_div_capacity (
      .clock     (clock),
      .reset     (reset),
      .div_num   (div2_num),
      .div_den   (div2_den),
      .carry_in  (n_c_ff),
      .div_quo   (div2_q),
      .carry_out (div2_c)
   );

   logic [63:0] fin_ch_ff;
   logic [63:0] fin_ch_in;
   logic [16:0] fin_sw_ff;
   logic [16:0] fin_sw_in;
   carry_type   fin_c_ff;

   always_comb begin
      fin_ch_in = div2_c.neg ? div2_q[0] : 64'd0;
      if (sat_moisture_ff == '0) begin
         fin_sw_in = ONE_Q16;
      end else if (div2_q[1] > 64'(ONE_Q16)) begin
         fin_sw_in = ONE_Q16;
      end else begin
         fin_sw_in = div2_q[1][16:0];
      end
   end

   always_ff @(posedge clock) begin
      fin_ch_ff <= fin_ch_in;
      fin_sw_ff <= fin_sw_in;
      fin_c_ff  <= div2_c;
      if (reset) begin
         fin_c_ff.valid <= 1'b0;
      end
   end

   logic [32:0] st_storage_ff;
   logic [32:0] st_storage_in;
   logic [63:0] st_ch_ff;
   logic [16:0] st_sw_ff;
   carry_type   st_c_ff;

   always_comb begin
      logic [48:0] sp;
      sp            = 49'(specific_storage_ff) * 49'(fin_sw_ff);
      st_storage_in = sp[48:16];
   end

   always_ff @(posedge clock) begin
      st_storage_ff <= st_storage_in;
      st_ch_ff      <= fin_ch_ff;
      st_sw_ff      <= fin_sw_ff;
      st_c_ff       <= fin_c_ff;
      if (reset) begin
         st_c_ff.valid <= 1'b0;
      end
   end

   // Output registers; the capacity sum saturates.
   logic        rsp_valid_ff;
   logic [15:0] rsp_moisture_ff;
   logic [16:0] rsp_ratio_ff;
   logic [16:0] rsp_perm_ff;
   logic [31:0] rsp_cap_ff;
   logic [31:0] rsp_cap_in;

   always_comb begin
      logic [64:0] sum;
      sum = 65'(st_ch_ff) + 65'(st_storage_ff);
      if (sum > 65'(CAP_MAX)) begin
         rsp_cap_in = CAP_MAX;
      end else begin
         rsp_cap_in = sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= st_c_ff.valid;
      end
      rsp_moisture_ff <= st_c_ff.theta;
      rsp_ratio_ff    <= st_sw_ff;
      rsp_perm_ff     <= st_c_ff.kr;
      rsp_cap_ff      <= rsp_cap_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_moisture          = rsp_moisture_ff;
   assign rsp_saturation_ratio  = rsp_ratio_ff;
   assign rsp_rel_permeability  = rsp_perm_ff;
   assign rsp_moisture_capacity = rsp_cap_ff;

   `SRCE_ASSERT_NEXT(a_accept_enters, start && !busy, in_c_ff.valid)
   `SRCE_ASSERT(a_logistic_range, !r_c_ff.valid || ((r_ff[0] <= ONE_Q32) && (r_ff[1] <= ONE_Q32)))
   `SRCE_ASSERT(a_ratio_range, !rsp_valid || ((rsp_saturation_ratio <= ONE_Q16) && (rsp_rel_permeability <= ONE_Q16)))
   `SRCE_ASSERT(a_moisture_bound, !rsp_valid || (rsp_moisture <= sat_moisture_ff) || (rsp_moisture == residual_moisture_ff))

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Soil retention curve evaluator testbench
// Drives pressure heads through the command port under several register
// settings and checks every transaction result against a bit-exact model.
// ----------------------------------------------------------------------------
module testbench;
   import srce_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [15:0] moisture;
      logic [16:0] sat_ratio;
      logic [16:0] kr;
      logic [31:0] capacity;
   } soil_state_type;

   typedef struct {
      logic [31:0]    head;
      bit             known;
      soil_state_type want;
   } head_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_head = '0;
   logic               rsp_valid;
   logic [15:0]        rsp_moisture;
   logic [16:0]        rsp_saturation_ratio;
   logic [16:0]        rsp_rel_permeability;
   logic [31:0]        rsp_moisture_capacity;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [39:0]        csr_wdata = '0;

   // Model copy of the curve parameters.
   logic [15:0] theta_s, theta_r, beta_q, gamma_q;
   logic [39:0] alpha_q, perm_a;
   logic [31:0] storage_q;

   soil_state_type pending_cells[$];
   int             errors = 0;
   int             cycles = 0;
   bit             calm = 1'b0;

   soil_retention_curve_eval u_top (.*);

   always #5 clock = ~clock;

   function automatic logic [63:0] log2_q20(input logic [63:0] v);
      int          e;
      logic [63:0] m, frac;
      e = 0;
      for (int i = 63; i > 0; i--) begin
         if (v[i] && e == 0) e = i;
      end
      m = (e <= 31) ? (v << (31 - e)) : (v >> (e - 31));
      frac = '0;
      for (int i = 0; i < 20; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return (64'(e) << 20) | frac;
   endfunction

   function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
      logic [63:0] root, trial;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   function automatic logic [63:0] pow2_frac(input logic [63:0] frac);
      logic [63:0] c, m;
      c = 64'h1_0000_0000;
      m = 64'h8000_0000;
      for (int j = 0; j < 20; j++) begin
         c = sqrt_floor(c << 31);
         if (frac[19 - j]) m = (m * c) >> 31;
      end
      return m;
   endfunction

   // 1/(1+2^d) in Q0.32 for a signed Q.32 exponent d.
   function automatic logic [63:0] curve_share(input longint d);
      logic [63:0] mag, k, s, den;
      mag = (d < 0) ? 64'(-d) : 64'(d);
      k = mag >> 32;
      if (k > 40) begin
         s = '0;
      end else begin
         den = ((64'd1 << 31) >> k) + pow2_frac((mag >> 12) & 64'hF_FFFF);
         s = ((64'd1 << 63) / den) >> k;
      end
      return (d >= 0) ? s : 64'h1_0000_0000 - s;
   endfunction

   function automatic longint curve_exponent(input logic [63:0] expo, input logic [63:0] lx,
                                            input logic [39:0] coef);
      logic [63:0] lc;
      lc = log2_q20((coef == 0) ? 64'd1 : 64'(coef));
      return longint'(expo * lx) - longint'(expo << 23) - longint'(lc << 12)
             + (longint'(8) << 32);
   endfunction

   function automatic soil_state_type soil_response(input logic [31:0] h);
      soil_state_type o;
      logic [63:0] x, diff, lx, r, rk, rr, theta, sw, kr, ch;
      ch = '0;
      if (h[31]) begin
         x = 64'(32'(-h));
         diff = (theta_r < theta_s) ? 64'(theta_s - theta_r) : 64'd0;
         lx = log2_q20(x);
         r = curve_share(curve_exponent(64'(beta_q), lx, alpha_q));
         rk = curve_share(curve_exponent(64'(gamma_q), lx, perm_a));
         rr = (r * (64'h1_0000_0000 - r)) >> 32;
         theta = 64'(theta_r) + ((diff * r) >> 32);
         kr = rk >> 16;
         ch = (rr * diff * 64'(beta_q)) / (x << 20);
      end else begin
         theta = 64'(theta_s);
         kr = 64'd65536;
      end
      if (theta_s == 0) begin
         sw = 64'd65536;
      end else begin
         sw = (theta << 16) / 64'(theta_s);
         if (sw > 64'd65536) sw = 64'd65536;
      end
      ch = ch + ((64'(storage_q) * sw) >> 16);
      if (ch > 64'hFFFF_FFFF) ch = 64'hFFFF_FFFF;
      o.moisture = theta[15:0];
      o.sat_ratio = sw[16:0];
      o.kr = kr[16:0];
      o.capacity = ch[31:0];
      return o;
   endfunction

   task automatic pause_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // One transaction; start stays high if the next call follows at once.
   task automatic send_head(input logic [31:0] h, input bit known, input soil_state_type want);
      soil_state_type guess;
      if (!calm && $urandom_range(99) < 33) pause_cycles(1);
      start <= 1'b1;
      req_head <= h;
      guess = soil_response(h);
      if (known && guess != want) begin
         $display("%0t table row %h disagrees with model: table %p model %p",
                  $realtime, h, want, guess);
         errors++;
      end
      do @(posedge clock); while (busy);
      pending_cells.push_back(known ? want : guess);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // The write enable stays high across back-to-back writes; write_all drops it.
   task automatic write_reg(input logic [2:0] idx, input logic [39:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_SAT_MOISTURE:      theta_s = val[15:0];
         CSR_RESIDUAL_MOISTURE: theta_r = val[15:0];
         CSR_RETENTION_ALPHA:   alpha_q = val;
         CSR_RETENTION_BETA:    beta_q = val[15:0];
         CSR_PERM_GAMMA:        gamma_q = val[15:0];
         CSR_PERM_COEFF:        perm_a = val;
         CSR_SPECIFIC_STORAGE:  storage_q = val[31:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [15:0] ts, input logic [15:0] tr, input logic [39:0] al,
                            input logic [15:0] be, input logic [15:0] ga, input logic [39:0] pa,
                            input logic [31:0] ss);
      write_reg(CSR_SAT_MOISTURE, 40'(ts));
      write_reg(CSR_RESIDUAL_MOISTURE, 40'(tr));
      write_reg(CSR_RETENTION_ALPHA, al);
      write_reg(CSR_RETENTION_BETA, 40'(be));
      write_reg(CSR_PERM_GAMMA, 40'(ga));
      write_reg(CSR_PERM_COEFF, pa);
      write_reg(CSR_SPECIFIC_STORAGE, 40'(ss));
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] random_head();
      int pick;
      pick = $urandom_range(9);
      if (pick < 3) return $urandom();
      if (pick < 6) return -32'($urandom_range(4096, 1));
      if (pick < 8) return -32'(($urandom() >> $urandom_range(31)) | 32'd1);
      return 32'($urandom_range(100000));
   endfunction

   task automatic random_batch(input int count);
      soil_state_type none;
      none = '{default: '0};
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) drain();
         send_head(random_head(), 1'b0, none);
      end
   endtask

   always @(posedge clock) begin
      soil_state_type want;
      if (!reset && rsp_valid) begin
         if (pending_cells.size() == 0) begin
            $display("%0t unexpected result: moisture %h", $realtime, rsp_moisture);
            errors++;
         end else begin
            want = pending_cells.pop_front();
            if (rsp_moisture !== want.moisture) begin
               $display("%0t moisture expected %h actual %h", $realtime,
                        want.moisture, rsp_moisture);
               errors++;
            end
            if (rsp_saturation_ratio !== want.sat_ratio) begin
               $display("%0t saturation_ratio expected %h actual %h", $realtime,
                        want.sat_ratio, rsp_saturation_ratio);
               errors++;
            end
            if (rsp_rel_permeability !== want.kr) begin
               $display("%0t rel_permeability expected %h actual %h", $realtime,
                        want.kr, rsp_rel_permeability);
               errors++;
            end
            if (rsp_moisture_capacity !== want.capacity) begin
               $display("%0t moisture_capacity expected %h actual %h", $realtime,
                        want.capacity, rsp_moisture_capacity);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[soil_retention_curve_eval] ERROR");
         $finish;
      end
   end

   initial begin
      head_row_type   rows[$];
      soil_state_type sat_cell;
      soil_state_type none;
      theta_s = 16'd18809;
      theta_r = 16'd4915;
      alpha_q = 40'd412416000;
      beta_q = 16'd16220;
      gamma_q = 16'd19415;
      perm_a = 40'd300800000;
      storage_q = '0;
      none = '{default: '0};
      sat_cell = '{moisture: 16'd18809, sat_ratio: ONE_Q16, kr: ONE_Q16, capacity: '0};

      // Saturated heads give theta_s, full ratio and permeability, no capacity.
      rows = '{
         '{32'h0000_0000, 1'b1, sat_cell},
         '{32'h0000_0001, 1'b1, sat_cell},
         '{32'h7FFF_FFFF, 1'b1, sat_cell},
         '{32'h0000_0100, 1'b1, sat_cell},
         '{32'hFFFF_FFFF, 1'b0, none},
         '{32'hFFFF_FF00, 1'b0, none},
         '{32'hFFFF_0000, 1'b0, none},
         '{32'h8000_0000, 1'b0, none},
         '{32'h8000_0001, 1'b0, none},
         '{32'hFFFF_FC00, 1'b0, none},
         '{32'hFFF0_0000, 1'b0, none},
         '{32'hAAAA_AAAA, 1'b0, none},
         '{32'hD555_5555, 1'b0, none}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_head(rows[i].head, rows[i].known, rows[i].want);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: write_all(16'd0, 16'd0, 40'd0, 16'd4096, 16'd0, 40'd0, 32'd0);
            1: write_all(16'd1000, 16'd60000, 40'd256, 16'd0, 16'd65535, 40'd1, 32'h8000_0000);
            2: write_all(16'hFFFF, 16'd0, 40'hFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF,
                         40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
            3: write_all(16'hFFFF, 16'd0, 40'd1, 16'd4096, 16'd4096, 40'd1, 32'hFFFF_FFFF);
            4: write_all(16'd18809, 16'd4915, 40'd412416000, 16'd2000, 16'd19415,
                         40'd300800000, 32'd12345);
            default: write_all(16'($urandom()), 16'($urandom_range(30000)),
                               {$urandom(), 8'($urandom())},
                               16'($urandom_range(65535, 4096)), 16'($urandom()),
                               {$urandom(), 8'($urandom())}, $urandom());
         endcase
         send_head(32'hFFFF_FFFF, 1'b0, none);
         send_head(32'h8000_0000, 1'b0, none);
         send_head(32'h0000_0000, 1'b0, none);
         calm = (phase == 5);
         random_batch(230);
         calm = 1'b0;
         drain();
      end

      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("[soil_retention_curve_eval] OK");
      end else begin
         $display("[soil_retention_curve_eval] ERROR");
      end
      $finish;
   end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/srce_pkg.sv
hw/rtl/srce_log2.sv
hw/rtl/srce_exp2.sv
hw/rtl/srce_div.sv
hw/rtl/soil_retention_curve_eval.sv
tb/testbench.sv
